### design/xorshift128_ranged_generator_core_assert.svh
// ----------------------------------------------------------------------------
// xorshift128 ranged generator assertion macros
// Shared concurrent assertion forms used by the generator modules.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT128_RANGED_GENERATOR_CORE_ASSERT_SVH
`define XORSHIFT128_RANGED_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define XRG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define XRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/xrg_pkg.sv
// ----------------------------------------------------------------------------
// xrg_pkg
// Types, constants and mixing functions shared by the generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package xrg_pkg;

    // seeding constants
    localparam logic [31:0] SEED_MULT = 32'd1812433253;
    localparam int          NUM_WORDS = 4;
    localparam int          IDX_W     = $clog2(NUM_WORDS);
    localparam logic [31:0] SEED_XOR [NUM_WORDS] = '{
        32'd123464980, 32'd3447902351, 32'd2859490775, 32'd47621719
    };

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // what the back end has to do with a job
    typedef enum logic [1:0] {
        JOB_RAW,
        JOB_EMPTY,
        JOB_RANGED
    } t_job_kind;

    // one classified request
    typedef struct packed {
        t_job_kind   kind;
        logic [31:0] raw_word;
        logic [31:0] range_low;
        logic [32:0] span;
    } t_job;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // add one and xorshift after the seed multiply
    function automatic logic [31:0] mix_tail(input logic [31:0] prod);
        logic [31:0] s;
        s = prod + 32'd1;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        return s;
    endfunction

    // new word_w of one xorshift128 step
    function automatic logic [31:0] next_word(input logic [31:0] x, input logic [31:0] w);
        logic [31:0] t;
        t = x ^ (x << 11);
        return w ^ t ^ (t >> 8) ^ (w >> 19);
    endfunction

endpackage

`default_nettype wire

### design/xrg_front.sv
// ----------------------------------------------------------------------------
// xrg_front
// Seeding sequencer, generator state, request classification and span setup.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xorshift128_ranged_generator_core_assert.svh"

module xrg_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_seed_we,
    input  wire logic [31:0]        i_seed_value,
    input  wire logic               i_push,
    input  wire logic               i_op,
    input  wire logic signed [31:0] i_range_low,
    input  wire logic signed [31:0] i_range_high,
    output logic                    o_full,
    input  wire xrg_pkg::t_q_status i_q_status,
    output logic                    o_job_push,
    output xrg_pkg::t_job           o_job
);
    import xrg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_MIX
    } t_state;

    t_state           r_state;
    logic [31:0]      r_seed;
    logic [31:0]      r_prod;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      r_word [NUM_WORDS];

    logic        accept;
    logic [31:0] mixed;
    logic [31:0] new_word;
    logic        all_zero;
    logic [32:0] diff;
    t_job_kind   kind;

    // seeding mix and the zero-state check on the last word
    assign mixed    = mix_tail(r_prod);
    assign new_word = SEED_XOR[r_idx] ^ mixed;
    assign all_zero = (r_word[0] == 32'd0) && (r_word[1] == 32'd0)
                   && (r_word[2] == 32'd0) && (new_word == 32'd0);

    // classify the request
    assign diff = {i_range_high[31], i_range_high} - {i_range_low[31], i_range_low};
    always_comb begin
        priority if (!i_op) begin
            kind = JOB_RAW;
        end else if (diff[32]) begin
            kind = JOB_EMPTY;
        end else begin
            kind = JOB_RANGED;
        end
    end

    assign o_full     = (r_state != S_IDLE) || i_q_status.full;
    assign accept     = i_push && !o_full;
    assign o_job_push = accept;

    always_comb begin
        o_job.kind      = kind;
        o_job.raw_word  = (kind == JOB_EMPTY) ? 32'd0
                        : next_word(r_word[0], r_word[NUM_WORDS-1]);
        o_job.range_low = i_range_low;
        o_job.span      = diff + 33'd1;
    end

    // seeding sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_MUL;
            r_seed  <= 32'd0;
            r_idx   <= '0;
        end else if (i_seed_we) begin
            r_state <= S_MUL;
            r_seed  <= i_seed_value;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_MUL: begin
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_seed <= mixed;
                    r_idx  <= r_idx + 1'b1;
                    if (r_idx == IDX_W'(NUM_WORDS - 1)) begin
                        r_state <= all_zero ? S_MUL : S_IDLE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_IDLE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // seed product, one multiply per mix step
    always_ff @(posedge i_clk) begin
        r_prod <= r_seed * SEED_MULT;
    end

    // generator words: written by seeding, shifted on each drawn word
    always_ff @(posedge i_clk) begin
        if (r_state == S_MIX) begin
            r_word[r_idx] <= new_word;
        end else if (accept && kind != JOB_EMPTY) begin
            for (int i = 0; i < NUM_WORDS - 1; i++) begin
                r_word[i] <= r_word[i+1];
            end
            r_word[NUM_WORDS-1] <= next_word(r_word[0], r_word[NUM_WORDS-1]);
        end
    end

    `XRG_ASSERT_NOW(a_state_nonzero, i_clk, i_rst_n,
        r_state == S_IDLE,
        (r_word[0] | r_word[1] | r_word[2] | r_word[3]) != 32'd0,
        "generator state is all zero")

endmodule

`default_nettype wire

### design/xrg_queue.sv
// ----------------------------------------------------------------------------
// xrg_queue
// Small job queue decoupling request classification from the divider.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xorshift128_ranged_generator_core_assert.svh"

module xrg_queue #(
    parameter int DEPTH = xrg_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire xrg_pkg::t_job i_job,
    input  wire logic          i_pop,
    output xrg_pkg::t_job      o_job,
    output xrg_pkg::t_q_status o_status
);
    import xrg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `XRG_ASSERT_NOW(a_count_bound, i_clk, i_rst_n,
        1'b1, r_count <= CNT_W'(DEPTH),
        "job queue count beyond depth")

    `XRG_ASSERT_NEXT(a_fill_to_full, i_clk, i_rst_n,
        do_push && !do_pop && r_count == CNT_W'(DEPTH - 1), o_status.full,
        "job queue did not report full")

endmodule

`default_nettype wire

### design/xrg_back.sv
// ----------------------------------------------------------------------------
// xrg_back
// Bit-serial remainder by the span, range offset and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xorshift128_ranged_generator_core_assert.svh"

module xrg_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire xrg_pkg::t_q_status i_q_status,
    input  wire xrg_pkg::t_job      i_job,
    output logic                    o_q_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic [31:0]             o_raw_word,
    output logic signed [31:0]      o_ranged_value
);
    import xrg_pkg::*;

    localparam int BITS  = 32;
    localparam int BIT_W = $clog2(BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state;
    t_job             r_job;
    logic [31:0]      r_rem;
    logic [31:0]      r_dvd;
    logic [BIT_W-1:0] r_bit;
    logic             r_out_valid;
    logic [31:0]      r_out_raw;
    logic [31:0]      r_out_ranged;

    logic [32:0] trial;
    logic        take;
    logic        load_out;
    logic [31:0] res_raw;
    logic [31:0] res_ranged;

    // one quotient bit per cycle
    assign trial = {r_rem, r_dvd[31]};
    assign take  = (trial >= r_job.span);

    assign o_q_pop  = (r_state == S_IDLE) && !i_q_status.empty;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_pop);

    // result of the finished job
    always_comb begin
        unique case (r_job.kind)
            JOB_RAW: begin
                res_raw    = r_job.raw_word;
                res_ranged = 32'd0;
            end
            JOB_EMPTY: begin
                res_raw    = 32'd0;
                res_ranged = r_job.range_low;
            end
            JOB_RANGED: begin
                res_raw    = r_job.raw_word;
                res_ranged = r_rem + r_job.range_low;
            end
            default: begin
                res_raw    = 32'd0;
                res_ranged = 32'd0;
            end
        endcase
    end

    // job sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= (i_job.kind == JOB_RANGED) ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    if (r_bit == BIT_W'(BITS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_job;
            r_dvd <= i_job.raw_word;
            r_rem <= 32'd0;
            r_bit <= '0;
        end else if (r_state == S_DIV) begin
            r_rem <= take ? 32'(trial - r_job.span) : trial[31:0];
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_bit <= r_bit + 1'b1;
        end
        if (load_out) begin
            r_out_raw    <= res_raw;
            r_out_ranged <= res_ranged;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_raw_word     = r_out_raw;
    assign o_ranged_value = r_out_ranged;

    `XRG_ASSERT_NOW(a_rem_below_span, i_clk, i_rst_n,
        r_state == S_DIV, {1'b0, r_rem} < r_job.span,
        "partial remainder not below span")

    `XRG_ASSERT_NEXT(a_div_length, i_clk, i_rst_n,
        r_state == S_IDLE && o_q_pop && i_job.kind == JOB_RANGED,
        r_state == S_DIV && r_bit == '0,
        "division did not start at the top bit")

endmodule

`default_nettype wire

### design/xorshift128_ranged_generator_core.sv
// ----------------------------------------------------------------------------
// xorshift128_ranged_generator_core
// xorshift128 word generator with raw and inclusive-range integer requests.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port (push/full) and results leave
// through another (pop/empty), one result word per request, in order. The
// front draws the generator word for a raw or ranged request in the cycle
// it is accepted; a raw request or one whose upper bound is below the lower
// bound passes through the job queue and the job register into the result
// register, and a ranged request also passes through the bit-serial
// remainder unit, which resolves one bit of the 32-bit word per cycle. A
// short job queue lets requests be accepted while the remainder unit is
// busy. Writing the seed register reseeds the generator by a multiply and a
// mix step per word (repeated if the words come out all zero); after reset
// the same sequence runs with seed zero, and full stays high until done.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift128_ranged_generator_core #(
    parameter int QUEUE_DEPTH = xrg_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_seed_we,
    input  wire logic [31:0]        i_seed_value,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               i_op,
    input  wire logic signed [31:0] i_range_low,
    input  wire logic signed [31:0] i_range_high,
    output logic                    empty,
    input  wire logic               pop,
    output logic [31:0]             o_raw_word,
    output logic signed [31:0]      o_ranged_value
);
    import xrg_pkg::*;

    t_q_status q_status;
    t_job      front_job;
    t_job      head_job;
    logic      job_push;
    logic      job_pop;

    // request front end
    xrg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_value (i_seed_value),
        .i_push       (push),
        .i_op         (i_op),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_full       (full),
        .i_q_status   (q_status),
        .o_job_push   (job_push),
        .o_job        (front_job)
    );

    // job queue
    xrg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (job_push),
        .i_job    (front_job),
        .i_pop    (job_pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // remainder unit and result word
    xrg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_job          (head_job),
        .o_q_pop        (job_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_raw_word     (o_raw_word),
        .o_ranged_value (o_ranged_value)
    );

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift128 ranged generator core testbench
// Drives raw and ranged requests through the push/full port under random
// bursts and gaps, pops words with a shifting stall pattern, and checks every
// word against a built-in xorshift128 predictor across several seeds.
// ----------------------------------------------------------------------------

module testbench;

    localparam logic [31:0]        SEED_MULT = 32'd1812433253;
    localparam logic [31:0]        SEED_X    = 32'd123464980;
    localparam logic [31:0]        SEED_Y    = 32'd3447902351;
    localparam logic [31:0]        SEED_Z    = 32'd2859490775;
    localparam logic [31:0]        SEED_W    = 32'd47621719;
    localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX   = 32'sh7fff_ffff;

    typedef enum logic {
        OP_RAW    = 1'b0,
        OP_RANGED = 1'b1
    } t_gen_op;

    typedef struct {
        t_gen_op            op;
        logic signed [31:0] low;
        logic signed [31:0] high;
    } t_gen_request;

    typedef struct {
        logic [31:0]        raw;
        logic signed [31:0] ranged;
    } t_gen_word;

    // predicts each word from its own copy of the generator state
    class generator_tracker;
        logic [31:0] wx, wy, wz, ww;
        t_gen_word   expected_words[$];
        int          errors, checked;
        int          raw_count, ranged_count, empty_count, full_span_count, seeds_applied;

        function logic [31:0] scramble(input logic [31:0] s);
            s = s * SEED_MULT + 32'd1;
            s = s ^ (s << 13);
            s = s ^ (s >> 17);
            return s;
        endfunction

        function void reseed(input logic [31:0] seed);
            logic [31:0] s;
            s = seed;
            do begin
                s  = scramble(s);
                wx = SEED_X ^ s;
                s  = scramble(s);
                wy = SEED_Y ^ s;
                s  = scramble(s);
                wz = SEED_Z ^ s;
                s  = scramble(s);
                ww = SEED_W ^ s;
            end while (wx == 0 && wy == 0 && wz == 0 && ww == 0);
            seeds_applied++;
        endfunction

        function logic [31:0] advance();
            logic [31:0] t;
            t  = wx ^ (wx << 11);
            wx = wy;
            wy = wz;
            wz = ww;
            ww = ww ^ t ^ (t >> 8) ^ (ww >> 19);
            return ww;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // accepted request: work out its word
        function void note_request(input t_gen_request req);
            t_gen_word   want;
            longint      span, rem;
            logic [31:0] r;
            if (req.op == OP_RAW) begin
                want.raw    = advance();
                want.ranged = '0;
                raw_count++;
            end else if (req.high < req.low) begin
                want.raw    = '0;
                want.ranged = req.low;
                empty_count++;
            end else begin
                // span in wide arithmetic, 1 up to 2^32
                span = longint'(req.high) - longint'(req.low) + 1;
                r    = advance();
                rem  = longint'({32'd0, r}) % span;
                want.raw    = r;
                want.ranged = 32'(rem + longint'(req.low));
                ranged_count++;
                if (span == 64'h1_0000_0000)
                    full_span_count++;
            end
            expected_words.push_back(want);
        endfunction

        task report_mismatch(input string what, input logic [31:0] got,
                             input logic [31:0] want);
            errors++;
            if (errors <= 30)
                $display("[%0t] mismatch %0d on %s: got %h, expected %h",
                         $time, errors, what, got, want);
        endtask

        // popped word against the oldest expectation
        task check_word(input logic [31:0] raw, input logic signed [31:0] ranged);
            t_gen_word want;
            if (expected_words.size() == 0) begin
                report_mismatch("word with nothing pending", raw, '0);
            end else begin
                want = expected_words.pop_front();
                checked++;
                if (raw !== want.raw)
                    report_mismatch("raw_word", raw, want.raw);
                if (ranged !== want.ranged)
                    report_mismatch("ranged_value", ranged, want.ranged);
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_seed_we;
    logic [31:0]        i_seed_value;
    logic               push;
    logic               full;
    logic               i_op;
    logic signed [31:0] i_range_low;
    logic signed [31:0] i_range_high;
    logic               empty;
    logic               pop;
    logic [31:0]        o_raw_word;
    logic signed [31:0] o_ranged_value;

    generator_tracker tracker;
    int               rx_mode;
    int               rx_left;

    xorshift128_ranged_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_we     (i_seed_we),
        .i_seed_value  (i_seed_value),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .empty         (empty),
        .pop           (pop),
        .o_raw_word    (o_raw_word),
        .o_ranged_value(o_ranged_value)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // receiver stall pattern, switching at random among four pop modes
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 300);
        end else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 9) == 0);
            default: pop <= ((rx_left / 8) % 2 == 0);
        endcase
    end

    // word monitor
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            tracker.check_word(o_raw_word, o_ranged_value);
    end

    function automatic t_gen_request make_request(input t_gen_op op,
                                                  input logic signed [31:0] low,
                                                  input logic signed [31:0] high);
        t_gen_request req;
        req.op   = op;
        req.low  = low;
        req.high = high;
        return req;
    endfunction

    function automatic logic signed [31:0] edge_bound();
        case ($urandom_range(0, 6))
            0: return S32_MIN;
            1: return S32_MIN + 1;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return S32_MAX - 1;
            default: return S32_MAX;
        endcase
    endfunction

    function automatic t_gen_request random_request();
        t_gen_request       req;
        logic signed [31:0] a, b;
        int                 pick;
        a    = $urandom;
        b    = $urandom;
        pick = $urandom_range(0, 99);
        req  = make_request(OP_RANGED, a, b);
        if (pick < 30) begin
            req.op = OP_RAW;
        end else if (pick < 40) begin
            // upper bound below lower bound
            if (a < b) begin
                req.low  = b;
                req.high = a;
            end
        end else if (pick < 55) begin
            req.high = a + $urandom_range(0, 15);
        end else if (pick < 65) begin
            req.low  = edge_bound();
            req.high = edge_bound();
        end else if (pick < 75) begin
            // spans near the full signed range
            req.low  = S32_MIN + $urandom_range(0, 3);
            req.high = S32_MAX - $urandom_range(0, 3);
        end else if (pick < 85) begin
            req.high = a + ((32'd1 << $urandom_range(0, 31)) - 32'd1);
        end
        return req;
    endfunction

    // hold the word until full is low at a rising edge
    task push_request(input t_gen_request req);
        @(negedge i_clk);
        push         = 1'b1;
        i_op         = req.op;
        i_range_low  = req.low;
        i_range_high = req.high;
        do @(posedge i_clk); while (full);
        tracker.note_request(req);
    endtask

    task sender_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            push         = 1'b0;
            i_op         = 1'($urandom);
            i_range_low  = $urandom;
            i_range_high = $urandom;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task drain_results();
        @(negedge i_clk);
        push = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // reseed only once the block is idle
    task write_seed(input logic [31:0] seed);
        drain_results();
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        i_seed_we    = 1'b1;
        i_seed_value = seed;
        @(posedge i_clk);
        tracker.reseed(seed);
        @(negedge i_clk);
        i_seed_we    = 1'b0;
        i_seed_value = $urandom;
    endtask

    task run_random(input int count, input bit no_gaps);
        int sent, burst, pick;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < count; i++) begin
                push_request(random_request());
                sent++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
                drain_results();
            else if (!no_gaps && pick >= 45)
                sender_gap(pick < 80 ? $urandom_range(1, 4) : $urandom_range(5, 45));
        end
    endtask

    task run_directed();
        push_request(make_request(OP_RAW, 0, 0));
        push_request(make_request(OP_RAW, S32_MIN, S32_MAX));
        push_request(make_request(OP_RAW, -1, -1));
        push_request(make_request(OP_RANGED, 0, 0));
        push_request(make_request(OP_RANGED, S32_MIN, S32_MIN));
        push_request(make_request(OP_RANGED, S32_MAX, S32_MAX));
        push_request(make_request(OP_RANGED, S32_MIN, S32_MAX));
        push_request(make_request(OP_RANGED, S32_MIN, S32_MAX));
        push_request(make_request(OP_RANGED, S32_MAX, S32_MIN));
        push_request(make_request(OP_RANGED, 5, 4));
        push_request(make_request(OP_RANGED, 0, -1));
        push_request(make_request(OP_RANGED, -1, 0));
        push_request(make_request(OP_RANGED, 0, 1));
        push_request(make_request(OP_RANGED, -10, 10));
        push_request(make_request(OP_RANGED, S32_MIN, -1));
        push_request(make_request(OP_RANGED, 0, S32_MAX));
        push_request(make_request(OP_RANGED, -1, S32_MAX));
        push_request(make_request(OP_RANGED, S32_MIN, 0));
        push_request(make_request(OP_RANGED, S32_MIN + 1, S32_MAX));
        push_request(make_request(OP_RANGED, 1, 100));
        push_request(make_request(OP_RANGED, -100, -1));
        push_request(make_request(OP_RAW, S32_MAX, S32_MIN));
    endtask

    // run limit
    initial begin
        #10ms;
        $display("xorshift128_ranged_generator_core test failed");
        $finish;
    end

    // main sequence
    initial begin
        tracker      = new();
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_seed_we    = 1'b0;
        i_seed_value = '0;
        push         = 1'b0;
        i_op         = OP_RAW;
        i_range_low  = '0;
        i_range_high = '0;
        pop          = 1'b0;
        rx_mode      = 0;
        rx_left      = 0;
        tracker.reseed(32'd0);

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset state first, then a spread of seeds
        run_directed();
        run_random(300, 1'b0);
        write_seed(32'hffff_ffff);
        run_random(300, 1'b0);
        write_seed(32'd0);
        run_random(250, 1'b1);
        write_seed(32'd1);
        run_random(250, 1'b0);
        write_seed($urandom);
        run_random(300, 1'b0);
        write_seed(32'h8000_0000);
        run_directed();
        run_random(300, 1'b0);

        drain_results();
        repeat (50) @(posedge i_clk);

        $display("checked %0d words: %0d raw, %0d ranged (%0d full span), %0d empty range",
                 tracker.checked, tracker.raw_count, tracker.ranged_count,
                 tracker.full_span_count, tracker.empty_count);
        $display("%0d seed settings applied, %0d mismatches",
                 tracker.seeds_applied, tracker.errors);
        if (tracker.errors == 0)
            $display("xorshift128_ranged_generator_core test passed");
        else
            $display("xorshift128_ranged_generator_core test failed");
        $finish;
    end

endmodule

### xorshift128_ranged_generator_core.f
+incdir+design
design/xrg_pkg.sv
design/xrg_front.sv
design/xrg_queue.sv
design/xrg_back.sv
design/xorshift128_ranged_generator_core.sv
sim/testbench.sv
